/* rtl/vad_seg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package vad_seg_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_ADDR_W      = 5;
    localparam int CFG_IDX_W       = 3;
    localparam int PROB_W          = 16;
    localparam int SEG_W           = 32;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SILENCE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPLIT_SILENCE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEECH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEECH    = 3'd6;

    localparam logic [15:0] THRESHOLD_RST     = 16'd32768;
    localparam logic [15:0] RELEASE_RST       = 16'd9830;
    localparam logic [15:0] WINDOW_RST        = 16'd512;
    localparam logic [31:0] MIN_SILENCE_RST   = 32'd1600;
    localparam logic [31:0] SPLIT_SILENCE_RST = 32'd1568;
    localparam logic [31:0] MIN_SPEECH_RST    = 32'd4000;
    localparam logic [31:0] MAX_SPEECH_RST    = 32'hFFFF_FFFF;
    localparam logic [31:0] SPLIT_OFF         = 32'hFFFF_FFFF;

    localparam logic FUNC_WINDOW = 1'b0;
    localparam logic FUNC_FLUSH  = 1'b1;

endpackage

`default_nettype wire

/* rtl/vad_speech_segmenter_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Speech segmenter: one beat per audio window carries a Q0.16 speech probability
// (or, with func set, an end-of-stream flush carrying the total sample count) and
// yields at most one (seg_start, seg_end) beat. An input register feeds a single
// pass of compare/update logic into the state and a result register, so one beat
// is taken every cycle while the result side is not stalled; a beat's result is
// registered after the input register. Counters are COUNT_WIDTH bits and wrap;
// result fields carry their low 32 bits. Write the APB registers only while idle.
module vad_speech_segmenter_unit #(
    parameter int COUNT_WIDTH = vad_seg_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output      logic                                 o_in_stall,
    input  wire logic                                 i_func,
    input  wire logic [vad_seg_pkg::PROB_W-1:0]       i_prob,
    input  wire logic [vad_seg_pkg::SEG_W-1:0]        i_stream_length,
    output      logic                                 o_out_valid,
    input  wire logic                                 i_out_stall,
    output      logic [vad_seg_pkg::SEG_W-1:0]        o_seg_start,
    output      logic [vad_seg_pkg::SEG_W-1:0]        o_seg_end,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [vad_seg_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [vad_seg_pkg::CFG_DATA_W-1:0]   pwdata,
    output      logic [vad_seg_pkg::CFG_DATA_W-1:0]   prdata,
    output      logic                                 pready
);
    import vad_seg_pkg::*;

    localparam int CW   = COUNT_WIDTH;
    localparam int XW   = (CW > SEG_W) ? CW : SEG_W;
    localparam int CMPW = XW + 1;

    // configuration
    logic [15:0] r_threshold, r_release, r_window;
    logic [31:0] r_min_silence, r_split_silence, r_min_speech, r_max_speech;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold     <= THRESHOLD_RST;
            r_release       <= RELEASE_RST;
            r_window        <= WINDOW_RST;
            r_min_silence   <= MIN_SILENCE_RST;
            r_split_silence <= SPLIT_SILENCE_RST;
            r_min_speech    <= MIN_SPEECH_RST;
            r_max_speech    <= MAX_SPEECH_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_THRESHOLD:     r_threshold     <= pwdata[15:0];
                REG_RELEASE:       r_release       <= pwdata[15:0];
                REG_WINDOW:        r_window        <= pwdata[15:0];
                REG_MIN_SILENCE:   r_min_silence   <= pwdata;
                REG_SPLIT_SILENCE: r_split_silence <= pwdata;
                REG_MIN_SPEECH:    r_min_speech    <= pwdata;
                REG_MAX_SPEECH:    r_max_speech    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_THRESHOLD:     prdata = {16'd0, r_threshold};
            REG_RELEASE:       prdata = {16'd0, r_release};
            REG_WINDOW:        prdata = {16'd0, r_window};
            REG_MIN_SILENCE:   prdata = r_min_silence;
            REG_SPLIT_SILENCE: prdata = r_split_silence;
            REG_MIN_SPEECH:    prdata = r_min_speech;
            REG_MAX_SPEECH:    prdata = r_max_speech;
            default:           prdata = '0;
        endcase
    end

    // input register
    logic              r_in_valid, r_in_func;
    logic [PROB_W-1:0] r_in_prob;
    logic [SEG_W-1:0]  r_in_len;
    logic              adv;

    assign adv        = !o_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_func <= i_func;
            r_in_prob <= i_prob;
            r_in_len  <= i_stream_length;
        end
    end

    // segmenter state
    logic          r_in_speech;
    logic [CW-1:0] r_count, r_tent, r_prev, r_resume, r_open;
    logic          n_in_speech;
    logic [CW-1:0] n_count, n_tent, n_prev, n_resume, n_open;
    logic          emit;
    logic [XW-1:0] emit_start, emit_end;

    logic [CW-1:0]     sc, ws, tent_use, d_open, d_quiet, d_seg;
    logic signed [17:0] falling;
    logic signed [CMPW-1:0] s_open, s_quiet, s_seg;
    logic signed [CMPW-1:0] c_max, c_split, c_minsil, c_minsp;
    logic hit, over_max, silent;

    assign ws       = CW'(r_window);
    assign sc       = r_count + ws;
    assign tent_use = (r_tent == '0) ? sc : r_tent;
    assign d_open   = sc - r_open;
    assign d_quiet  = sc - tent_use;
    assign d_seg    = tent_use - r_open;
    assign s_open   = $signed({{(CMPW-CW){d_open[CW-1]}}, d_open});
    assign s_quiet  = $signed({{(CMPW-CW){d_quiet[CW-1]}}, d_quiet});
    assign s_seg    = $signed({{(CMPW-CW){d_seg[CW-1]}}, d_seg});
    assign c_max    = $signed({{(CMPW-SEG_W){1'b0}}, r_max_speech});
    assign c_split  = $signed({{(CMPW-SEG_W){1'b0}}, r_split_silence});
    assign c_minsil = $signed({{(CMPW-SEG_W){1'b0}}, r_min_silence});
    assign c_minsp  = $signed({{(CMPW-SEG_W){1'b0}}, r_min_speech});
    assign falling  = $signed({2'b00, r_threshold}) - $signed({2'b00, r_release});
    assign hit      = r_in_prob >= r_threshold;
    assign over_max = r_in_speech && (r_max_speech != SPLIT_OFF) && (s_open > c_max);
    assign silent   = $signed({2'b00, r_in_prob}) < falling;

    always_comb begin
        n_in_speech = r_in_speech;
        n_count     = r_count;
        n_tent      = r_tent;
        n_prev      = r_prev;
        n_resume    = r_resume;
        n_open      = r_open;
        emit        = 1'b0;
        emit_start  = XW'(r_open);
        emit_end    = XW'(tent_use);
        if (r_in_func == FUNC_FLUSH) begin
            emit        = r_in_speech;
            emit_end    = XW'(r_in_len);
            n_in_speech = 1'b0;
            n_count     = '0;
            n_tent      = '0;
            n_prev      = '0;
            n_resume    = '0;
            n_open      = '0;
        end else begin
            n_count = sc;
            if (hit) begin
                if (r_tent != '0) begin
                    n_tent = '0;
                    if (r_resume < r_prev) begin
                        n_resume = r_count;
                    end
                end
                if (!r_in_speech) begin
                    n_in_speech = 1'b1;
                    n_open      = r_count;
                end
            end else if (over_max) begin
                emit     = 1'b1;
                n_prev   = '0;
                n_resume = '0;
                n_tent   = '0;
                if (r_prev != '0) begin
                    emit_end = XW'(r_prev);
                    if (r_resume < r_prev) begin
                        n_in_speech = 1'b0;
                        n_open      = '0;
                    end else begin
                        n_open = r_resume;
                    end
                end else begin
                    emit_end    = XW'(sc);
                    n_in_speech = 1'b0;
                    n_open      = '0;
                end
            end else if (silent && r_in_speech) begin
                n_tent = tent_use;
                if (s_quiet > c_split) begin
                    n_prev = tent_use;
                end
                if (s_quiet >= c_minsil && s_seg > c_minsp) begin
                    emit        = 1'b1;
                    n_in_speech = 1'b0;
                    n_open      = '0;
                    n_prev      = '0;
                    n_resume    = '0;
                    n_tent      = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_speech <= 1'b0;
            r_count     <= '0;
            r_tent      <= '0;
            r_prev      <= '0;
            r_resume    <= '0;
            r_open      <= '0;
        end else if (r_in_valid && adv) begin
            r_in_speech <= n_in_speech;
            r_count     <= n_count;
            r_tent      <= n_tent;
            r_prev      <= n_prev;
            r_resume    <= n_resume;
            r_open      <= n_open;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (adv) begin
            o_out_valid <= r_in_valid && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_valid && emit) begin
            o_seg_start <= emit_start[SEG_W-1:0];
            o_seg_end   <= emit_end[SEG_W-1:0];
        end
    end

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_speech |-> (r_tent == '0 && r_prev == '0 && r_resume == '0))
        else $error("split bookkeeping left set outside speech");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && adv && r_in_func == FUNC_FLUSH) |=>
            (!r_in_speech && r_count == '0))
        else $error("flush did not clear segmenter state");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && adv && r_in_func == FUNC_WINDOW) |=>
            (r_count == $past(sc)))
        else $error("sample counter did not advance by one window");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_stall) |-> (o_out_valid && r_in_valid))
        else $error("input stalled without a blocked result");

endmodule

`default_nettype wire
